### rtl/lobm_pkg.sv
// Package for the order book matcher: command and status codes, trade cap,
// queued command type and engine state type. No dependencies.
package lobm_pkg;

    typedef enum logic [2:0] {
        CMD_ADD     = 3'd0,
        CMD_CANCEL  = 3'd1,
        CMD_MODIFY  = 3'd2,
        CMD_EXECUTE = 3'd3,
        CMD_MATCH   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_DUP     = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    localparam int MATCH_CAP = 31;

    typedef struct packed {
        logic [2:0]         command;
        logic [31:0]        order_id;
        logic               side;
        logic signed [31:0] price;
        logic [31:0]        quantity;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_EMIT,
        S_WAIT
    } t_state;

endpackage

### rtl/lobm_front.sv
// Front end: accepts commands and holds them in a short queue.
// Depends on lobm_pkg.
module lobm_front
    import lobm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_item       i_item,
    output logic        o_q_valid,
    input  logic        i_q_take,
    output t_item       o_q_item
);
    t_item      r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_push, w_pop;

    assign o_stall   = (r_cnt == 3'd4);
    assign w_push    = i_valid && !o_stall;
    assign w_pop     = i_q_take && (r_cnt != 3'd0);
    assign o_q_valid = (r_cnt != 3'd0);
    assign o_q_item  = r_mem[r_rp];

    // store transfer
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_item;
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 2'd1;
            if (w_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b0, w_push} - {2'b0, w_pop};
        end
    end
endmodule

### rtl/lobm_back.sv
// Back end: table of resting orders, sequential scan and result output.
// Depends on lobm_pkg.
module lobm_back
    import lobm_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_take,
    input  t_item              i_q_item,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_result_kind,
    output logic [1:0]         o_status,
    output logic [31:0]        o_bid_order_id,
    output logic [31:0]        o_ask_order_id,
    output logic signed [31:0] o_trade_price,
    output logic [31:0]        o_trade_quantity,
    output logic               o_best_bid_valid,
    output logic signed [31:0] o_best_bid,
    output logic               o_best_ask_valid,
    output logic signed [31:0] o_best_ask,
    output logic               o_last
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // table
    logic                r_v   [SLOTS];
    logic [31:0]         r_id  [SLOTS];
    logic                r_sd  [SLOTS];
    logic signed [31:0]  r_pr  [SLOTS];
    logic [31:0]         r_qt  [SLOTS];
    logic [63:0]         r_sq  [SLOTS];
    logic [63:0]         r_seq;

    t_state r_st, n_st;
    t_item  r_cmd;
    logic [IW-1:0] r_ix;
    logic [4:0]    r_ntr;
    // scan results
    logic          r_hit, r_fr, r_bv, r_av;
    logic [IW-1:0] r_hk, r_fk, r_bk, r_ak;
    // output register
    logic          r_ov;

    logic          w_last_ix;
    logic [IW-1:0] w_ix;
    logic          w_bb, w_ba;
    logic          w_cross;
    logic [31:0]   w_t;

    assign w_ix      = r_ix;
    assign w_last_ix = (r_ix == IW'(SLOTS - 1));
    assign o_valid   = r_ov;

    // entry better than current best on its side
    always_comb begin
        w_bb = 1'b0;
        if (!r_bv) w_bb = 1'b1;
        else if (r_pr[w_ix] == r_pr[r_bk]) w_bb = r_sq[w_ix] < r_sq[r_bk];
        else w_bb = r_pr[w_ix] > r_pr[r_bk];
        w_ba = 1'b0;
        if (!r_av) w_ba = 1'b1;
        else if (r_pr[w_ix] == r_pr[r_ak]) w_ba = r_sq[w_ix] < r_sq[r_ak];
        else w_ba = r_pr[w_ix] < r_pr[r_ak];
    end

    assign w_cross = (r_cmd.command == CMD_MATCH) && r_bv && r_av &&
                     (r_pr[r_bk] >= r_pr[r_ak]) && (r_ntr < 5'(MATCH_CAP));
    assign w_t = (r_qt[r_bk] < r_qt[r_ak]) ? r_qt[r_bk] : r_qt[r_ak];

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:   if (i_q_valid) n_st = S_SCAN;
            S_SCAN:   if (w_last_ix) n_st = S_DECIDE;
            S_DECIDE: n_st = (r_cmd.command != CMD_MATCH) ? S_SCAN : S_EMIT;
            S_EMIT:   if (!r_ov || !i_stall) n_st = S_WAIT;
            S_WAIT:   if (!r_ov || !i_stall) n_st = (o_last) ? S_IDLE : S_SCAN;
            default:  n_st = S_IDLE;
        endcase
    end

    assign o_q_take = (r_st == S_IDLE) && i_q_valid;

    // control and table registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ov <= 1'b0; r_seq <= '0;
            for (int i = 0; i < SLOTS; i++) r_v[i] <= 1'b0;
        end else begin
            r_st <= n_st;
            // raise valid on emit, drop it once the result transfers
            if (r_st == S_EMIT && (!r_ov || !i_stall)) r_ov <= 1'b1;
            else if (r_ov && !i_stall) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: if (i_q_valid) begin
                    r_cmd <= i_q_item; r_ntr <= '0;
                end
                S_DECIDE: begin
                    // apply the command
                    if (r_cmd.command == CMD_ADD) begin
                        if (!r_hit && r_fr) begin
                            r_seq <= r_seq + 64'd1;
                            r_v[r_fk] <= 1'b1; r_id[r_fk] <= r_cmd.order_id;
                            r_sd[r_fk] <= r_cmd.side; r_pr[r_fk] <= r_cmd.price;
                            r_qt[r_fk] <= r_cmd.quantity; r_sq[r_fk] <= r_seq + 64'd1;
                        end
                    end else if (r_cmd.command == CMD_CANCEL ||
                                 r_cmd.command == CMD_MODIFY ||
                                 r_cmd.command == CMD_EXECUTE) begin
                        if (r_hit) begin
                            if (r_cmd.command == CMD_CANCEL ||
                                (r_cmd.command == CMD_MODIFY && r_cmd.quantity == '0)) begin
                                r_v[r_hk] <= 1'b0;
                            end else if (r_cmd.command == CMD_MODIFY) begin
                                if (r_qt[r_hk] < r_cmd.quantity) begin
                                    r_seq <= r_seq + 64'd1;
                                    r_sq[r_hk] <= r_seq + 64'd1;
                                end
                                r_qt[r_hk] <= r_cmd.quantity;
                            end else if (r_qt[r_hk] <= r_cmd.quantity) begin
                                r_v[r_hk] <= 1'b0;
                            end else begin
                                r_qt[r_hk] <= r_qt[r_hk] - r_cmd.quantity;
                            end
                        end
                    end
                    // non-match commands rescan for the status prices, trading nothing
                    if (r_cmd.command != CMD_MATCH) begin
                        r_cmd.command <= CMD_MATCH;
                        r_ntr <= 5'(MATCH_CAP);
                    end
                end
                S_EMIT: if (!r_ov || !i_stall) begin
                    if (w_cross) begin
                        r_ntr <= r_ntr + 5'd1;
                        r_qt[r_bk] <= r_qt[r_bk] - w_t;
                        r_qt[r_ak] <= r_qt[r_ak] - w_t;
                        if (r_qt[r_bk] == w_t) r_v[r_bk] <= 1'b0;
                        if (r_qt[r_ak] == w_t) r_v[r_ak] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // scan one entry per cycle
    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE, S_WAIT: begin
                r_ix <= '0; r_hit <= 1'b0; r_fr <= 1'b0; r_bv <= 1'b0; r_av <= 1'b0;
            end
            S_SCAN: begin
                if (!w_last_ix) r_ix <= r_ix + IW'(1);
                if (r_v[w_ix] && r_id[w_ix] == r_cmd.order_id && !r_hit) begin
                    r_hit <= 1'b1; r_hk <= w_ix;
                end
                if (!r_v[w_ix] && !r_fr) begin
                    r_fr <= 1'b1; r_fk <= w_ix;
                end
                if (r_v[w_ix] && !r_sd[w_ix] && w_bb) begin
                    r_bv <= 1'b1; r_bk <= w_ix;
                end
                if (r_v[w_ix] && r_sd[w_ix] && w_ba) begin
                    r_av <= 1'b1; r_ak <= w_ix;
                end
            end
            S_DECIDE: begin
                // table changed for non-match commands: restart the best-price scan
                if (r_cmd.command != CMD_MATCH) begin
                    r_ix <= '0; r_bv <= 1'b0; r_av <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    // the second scan feeds the status item; track phases
    logic   r_p2;
    logic [1:0] r_stat;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p2 <= 1'b0;
        else if (r_st == S_IDLE) r_p2 <= 1'b0;
        else if (r_st == S_DECIDE && r_cmd.command != CMD_MATCH) r_p2 <= 1'b1;
    end
    always_ff @(posedge i_clk) begin
        if (r_st == S_DECIDE && !r_p2) begin
            case (r_cmd.command)
                CMD_ADD:   r_stat <= r_hit ? ST_DUP : (r_fr ? ST_DONE : ST_FULL);
                CMD_CANCEL, CMD_MODIFY, CMD_EXECUTE:
                           r_stat <= r_hit ? ST_DONE : ST_UNKNOWN;
                default:   r_stat <= ST_DONE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_st == S_EMIT && (!r_ov || !i_stall)) begin
            o_result_kind    <= w_cross;
            o_status         <= w_cross ? 2'd0 : r_stat;
            o_bid_order_id   <= w_cross ? r_id[r_bk] : '0;
            o_ask_order_id   <= w_cross ? r_id[r_ak] : '0;
            o_trade_price    <= !w_cross ? '0 :
                                (r_sq[r_bk] < r_sq[r_ak]) ? r_pr[r_bk] : r_pr[r_ak];
            o_trade_quantity <= w_cross ? w_t : '0;
            o_best_bid_valid <= !w_cross && r_bv;
            o_best_bid       <= (!w_cross && r_bv) ? r_pr[r_bk] : '0;
            o_best_ask_valid <= !w_cross && r_av;
            o_best_ask       <= (!w_cross && r_av) ? r_pr[r_ak] : '0;
            o_last           <= !w_cross;
        end
    end
endmodule

### rtl/limit_order_book_matcher.sv
// Top level of the order book matcher: front queue plus back engine.
// Depends on lobm_pkg, lobm_front, lobm_back.
//
// Commands enter on i_valid/o_stall and land in a four-entry queue; the
// back end takes one command at a time. Each command scans the order table
// one slot a cycle for id match, free slot and best bid/ask; non-match
// commands then rescan for the status prices. A match command rescans
// after every trade. Results leave through an output register on
// o_valid/i_stall; a stall holds it and the engine waits. A synchronous low
// reset empties the queue, clears all valid bits and the sequence counter;
// no clearing pass is needed.
module limit_order_book_matcher
    import lobm_pkg::*;
#(
    parameter int ORDER_SLOTS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_command,
    input  logic [31:0]        i_order_id,
    input  logic               i_side,
    input  logic signed [31:0] i_price,
    input  logic [31:0]        i_quantity,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_result_kind,
    output logic [1:0]         o_status,
    output logic [31:0]        o_bid_order_id,
    output logic [31:0]        o_ask_order_id,
    output logic signed [31:0] o_trade_price,
    output logic [31:0]        o_trade_quantity,
    output logic               o_best_bid_valid,
    output logic signed [31:0] o_best_bid,
    output logic               o_best_ask_valid,
    output logic signed [31:0] o_best_ask,
    output logic               o_last
);
    t_item w_in, w_q;
    logic  w_qv, w_take;

    assign w_in = '{command: i_command, order_id: i_order_id, side: i_side,
                    price: i_price, quantity: i_quantity};

    lobm_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item(w_in),
        .o_q_valid(w_qv), .i_q_take(w_take), .o_q_item(w_q)
    );

    lobm_back #(.SLOTS(ORDER_SLOTS)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(w_qv), .o_q_take(w_take), .i_q_item(w_q),
        .o_valid, .i_stall, .o_result_kind, .o_status, .o_bid_order_id,
        .o_ask_order_id, .o_trade_price, .o_trade_quantity, .o_best_bid_valid,
        .o_best_bid, .o_best_ask_valid, .o_best_ask, .o_last
    );
endmodule

### rtl/lobm_checker.sv
// Port checker for the order book matcher, bound to the top level.
// Depends on limit_order_book_matcher ports only.
module lobm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_result_kind,
    input logic        o_last,
    input logic [1:0]  o_status,
    input logic [31:0] o_trade_quantity
);
    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_last))
        else $error("stalled result changed");
    // trades never end a command
    a_trade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind |-> !o_last && o_status == 2'd0)
        else $error("trade item marked last");
    // status items carry no trade quantity
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result_kind |-> o_last && o_trade_quantity == '0)
        else $error("status item malformed");
endmodule

bind limit_order_book_matcher lobm_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_result_kind, .o_last,
    .o_status, .o_trade_quantity
);

### tb/tb_limit_order_book_matcher.sv
// Self-checking testbench for limit_order_book_matcher: a driver feeds commands
// from a queue, and a built-in order book predictor checks each result item.
// Depends on lobm_pkg and the limit_order_book_matcher RTL.
module tb_limit_order_book_matcher;
    import lobm_pkg::*;

    localparam int SLOTS = 32;
    localparam int IDLE_LIMIT = 6000;
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;
    localparam logic RESULT_STATUS = 1'b0;
    localparam logic RESULT_TRADE = 1'b1;
    localparam logic SIDE_BUY = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef struct {
        logic               kind;
        logic [1:0]         status;
        logic [31:0]        bid_id;
        logic [31:0]        ask_id;
        logic signed [31:0] trade_price;
        logic [31:0]        trade_qty;
        logic               bid_valid;
        logic signed [31:0] bid;
        logic               ask_valid;
        logic signed [31:0] ask;
        logic               last;
    } t_book_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_command = '0;
    logic [31:0]        i_order_id = '0;
    logic               i_side = 1'b0;
    logic signed [31:0] i_price = '0;
    logic [31:0]        i_quantity = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_result_kind;
    logic [1:0]         o_status;
    logic [31:0]        o_bid_order_id;
    logic [31:0]        o_ask_order_id;
    logic signed [31:0] o_trade_price;
    logic [31:0]        o_trade_quantity;
    logic               o_best_bid_valid;
    logic signed [31:0] o_best_bid;
    logic               o_best_ask_valid;
    logic signed [31:0] o_best_ask;
    logic               o_last;

    limit_order_book_matcher #(.ORDER_SLOTS(SLOTS)) u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Book model state
    logic               book_valid [SLOTS];
    logic [31:0]        book_id    [SLOTS];
    logic               book_side  [SLOTS];
    logic signed [31:0] book_price [SLOTS];
    logic [31:0]        book_qty   [SLOTS];
    logic [63:0]        book_seq   [SLOTS];
    logic [63:0]        seq_count;

    t_item        pending_cmds [$];
    t_book_result expected_results [$];
    int           mismatches = 0;
    int           accepted_cmds = 0;
    bit           hold_done = 1'b0;

    // Append to the tail of the command and result queues
    task automatic queue_cmd(t_item it);
        pending_cmds.insert(pending_cmds.size(), it);
    endtask

    task automatic queue_result(t_book_result r);
        expected_results.insert(expected_results.size(), r);
    endtask

    function automatic int find_order(logic [31:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (book_valid[i] && book_id[i] == id) return i;
        return -1;
    endfunction

    // Oldest order at the best price of one side, or -1 if that side is empty
    function automatic int find_best(logic sd);
        int best;
        bit better;
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (!book_valid[i] || book_side[i] != sd) continue;
            if (best < 0) begin
                best = i;
                continue;
            end
            if (book_price[i] == book_price[best])
                better = book_seq[i] < book_seq[best];
            else if (sd == SIDE_BUY)
                better = book_price[i] > book_price[best];
            else
                better = book_price[i] < book_price[best];
            if (better) best = i;
        end
        return best;
    endfunction

    // Apply one command to the book and queue the result items it yields
    task automatic apply_book_command(t_item it);
        t_book_result r;
        logic [1:0] st;
        logic [31:0] t;
        int k, b, a, n;
        st = ST_DONE;
        n = 0;
        if (it.command == CMD_ADD) begin
            if (find_order(it.order_id) >= 0) begin
                st = ST_DUP;
            end else begin
                k = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (!book_valid[i] && k < 0) k = i;
                if (k < 0) begin
                    st = ST_FULL;
                end else begin
                    seq_count++;
                    book_valid[k] = 1'b1;
                    book_id[k] = it.order_id;
                    book_side[k] = it.side;
                    book_price[k] = it.price;
                    book_qty[k] = it.quantity;
                    book_seq[k] = seq_count;
                end
            end
        end else if (it.command == CMD_CANCEL || it.command == CMD_MODIFY ||
                     it.command == CMD_EXECUTE) begin
            k = find_order(it.order_id);
            if (k < 0) begin
                st = ST_UNKNOWN;
            end else if (it.command == CMD_CANCEL ||
                         (it.command == CMD_MODIFY && it.quantity == 0)) begin
                book_valid[k] = 1'b0;
            end else if (it.command == CMD_MODIFY) begin
                // a larger size loses its place in time
                if (book_qty[k] < it.quantity) begin
                    seq_count++;
                    book_seq[k] = seq_count;
                end
                book_qty[k] = it.quantity;
            end else if (book_qty[k] <= it.quantity) begin
                book_valid[k] = 1'b0;
            end else begin
                book_qty[k] -= it.quantity;
            end
        end else if (it.command == CMD_MATCH) begin
            while (n < MATCH_CAP) begin
                b = find_best(SIDE_BUY);
                a = find_best(SIDE_SELL);
                if (b < 0 || a < 0) break;
                if (book_price[b] < book_price[a]) break;
                t = (book_qty[b] < book_qty[a]) ? book_qty[b] : book_qty[a];
                r = '{default: '0};
                r.kind = RESULT_TRADE;
                r.bid_id = book_id[b];
                r.ask_id = book_id[a];
                r.trade_price = (book_seq[b] < book_seq[a]) ? book_price[b] : book_price[a];
                r.trade_qty = t;
                queue_result(r);
                n++;
                book_qty[b] -= t;
                book_qty[a] -= t;
                if (book_qty[b] == 0) book_valid[b] = 1'b0;
                if (book_qty[a] == 0) book_valid[a] = 1'b0;
            end
        end
        b = find_best(SIDE_BUY);
        a = find_best(SIDE_SELL);
        r = '{default: '0};
        r.kind = RESULT_STATUS;
        r.status = st;
        r.bid_valid = (b >= 0);
        r.bid = (b >= 0) ? book_price[b] : '0;
        r.ask_valid = (a >= 0);
        r.ask = (a >= 0) ? book_price[a] : '0;
        r.last = 1'b1;
        queue_result(r);
    endtask

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        $display("t=%0t result %s: got %0h, expected %0h", $realtime, field, got, want);
        mismatches++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: present the next pending command, with random gaps
    int send_gap = 0;
    always @(posedge i_clk) begin
        t_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                apply_book_command('{i_command, i_order_id, i_side, i_price, i_quantity});
                accepted_cmds++;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    nxt = pending_cmds.pop_front();
                    i_command <= nxt.command;
                    i_order_id <= nxt.order_id;
                    i_side <= nxt.side;
                    i_price <= nxt.price;
                    i_quantity <= nxt.quantity;
                    i_valid <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random stalls, one long hold to back up the input queue
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_book_result w;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    report("unexpected item", o_result_kind, 0);
                end else begin
                    w = expected_results.pop_front();
                    if (o_result_kind !== w.kind) report("kind", o_result_kind, w.kind);
                    if (o_status !== w.status) report("status", o_status, w.status);
                    if (o_bid_order_id !== w.bid_id)
                        report("bid id", o_bid_order_id, w.bid_id);
                    if (o_ask_order_id !== w.ask_id)
                        report("ask id", o_ask_order_id, w.ask_id);
                    if (o_trade_price !== w.trade_price)
                        report("trade price", o_trade_price, w.trade_price);
                    if (o_trade_quantity !== w.trade_qty)
                        report("trade qty", o_trade_quantity, w.trade_qty);
                    if (o_best_bid_valid !== w.bid_valid)
                        report("bid valid", o_best_bid_valid, w.bid_valid);
                    if (o_best_bid !== w.bid) report("best bid", o_best_bid, w.bid);
                    if (o_best_ask_valid !== w.ask_valid)
                        report("ask valid", o_best_ask_valid, w.ask_valid);
                    if (o_best_ask !== w.ask) report("best ask", o_best_ask, w.ask);
                    if (o_last !== w.last) report("last", o_last, w.last);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!hold_done && accepted_cmds >= 80) begin
                hold_done = 1'b1;
                stall_left = 600;
                i_stall <= 1'b1;
            end else begin
                stall_left = pick_gap();
                i_stall <= (stall_left > 0);
            end
        end
    end

    // Watchdog: end the run if nothing transfers for too long
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_item mk(logic [2:0] c, logic [31:0] id, logic sd,
                                 logic signed [31:0] p, logic [31:0] q);
        t_item it;
        it.command = c;
        it.order_id = id;
        it.side = sd;
        it.price = p;
        it.quantity = q;
        return it;
    endfunction

    function automatic t_item rand_cmd();
        t_item it;
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) it.command = CMD_ADD;
        else if (r < 50) it.command = CMD_CANCEL;
        else if (r < 65) it.command = CMD_MODIFY;
        else if (r < 77) it.command = CMD_EXECUTE;
        else if (r < 97) it.command = CMD_MATCH;
        else it.command = 3'($urandom_range(CMD_RSVD5, CMD_RSVD7));
        r = $urandom_range(0, 99);
        if (r < 90) it.order_id = $urandom_range(1, 40);
        else if (r < 95) it.order_id = $urandom;
        else it.order_id = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        it.side = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 90) it.price = 1000 + $urandom_range(0, 16) - 8;
        else if (r < 95) it.price = $urandom;
        else it.price = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        r = $urandom_range(0, 99);
        if (r < 80) it.quantity = $urandom_range(1, 20);
        else if (r < 90) it.quantity = 0;
        else it.quantity = $urandom;
        return it;
    endfunction

    initial begin
        for (int i = 0; i < SLOTS; i++) book_valid[i] = 1'b0;
        seq_count = '0;

        // Extremes, duplicate, zero-size order, unknown ids, modify/execute paths
        queue_cmd(mk(CMD_ADD, 32'h0, SIDE_BUY, 32'sh7FFF_FFFF, 32'hFFFF_FFFF));
        queue_cmd(mk(CMD_ADD, 32'hFFFF_FFFF, SIDE_SELL, 32'sh8000_0000, 32'h0));
        queue_cmd(mk(CMD_ADD, 32'h0, SIDE_SELL, 32'sd5, 32'd3));
        queue_cmd(mk(CMD_MATCH, 32'h0, SIDE_BUY, 32'sd0, 32'd0));
        queue_cmd(mk(CMD_CANCEL, 32'h1234_5678, SIDE_BUY, 32'sd0, 32'd0));
        queue_cmd(mk(CMD_MODIFY, 32'h1234_5678, SIDE_BUY, 32'sd0, 32'd4));
        queue_cmd(mk(CMD_EXECUTE, 32'h1234_5678, SIDE_BUY, 32'sd0, 32'd4));
        queue_cmd(mk(CMD_ADD, 32'd7, SIDE_BUY, 32'sd7, 32'd10));
        queue_cmd(mk(CMD_ADD, 32'd8, SIDE_BUY, 32'sd7, 32'd10));
        queue_cmd(mk(CMD_MODIFY, 32'd7, SIDE_BUY, 32'sd0, 32'd6));
        queue_cmd(mk(CMD_MODIFY, 32'd7, SIDE_BUY, 32'sd0, 32'd12));
        queue_cmd(mk(CMD_EXECUTE, 32'd8, SIDE_BUY, 32'sd0, 32'd4));
        queue_cmd(mk(CMD_EXECUTE, 32'd8, SIDE_BUY, 32'sd0, 32'd6));
        queue_cmd(mk(CMD_MODIFY, 32'd7, SIDE_BUY, 32'sd0, 32'd0));
        queue_cmd(mk(CMD_CANCEL, 32'h0, SIDE_BUY, 32'sd0, 32'd0));
        queue_cmd(mk(CMD_RSVD5, 32'd1, SIDE_SELL, 32'sd1, 32'd1));
        queue_cmd(mk(CMD_RSVD6, 32'd1, SIDE_SELL, 32'sd1, 32'd1));
        queue_cmd(mk(CMD_RSVD7, 32'd1, SIDE_SELL, 32'sd1, 32'd1));
        queue_cmd(mk(CMD_MATCH, 32'd0, SIDE_BUY, 32'sd0, 32'd0));

        // Fill the table: one big bid against 31 small asks, overflow, capped match
        queue_cmd(mk(CMD_ADD, 32'd500, SIDE_BUY, 32'sd60, 32'd1000));
        for (int i = 0; i < SLOTS - 1; i++)
            queue_cmd(mk(CMD_ADD, 32'd501 + i, SIDE_SELL,
                         32'sd40 + $urandom_range(0, 15), 32'd1));
        queue_cmd(mk(CMD_ADD, 32'd900, SIDE_SELL, 32'sd10, 32'd1));
        queue_cmd(mk(CMD_MATCH, 32'd0, SIDE_BUY, 32'sd0, 32'd0));
        queue_cmd(mk(CMD_MATCH, 32'd0, SIDE_BUY, 32'sd0, 32'd0));
        queue_cmd(mk(CMD_CANCEL, 32'd500, SIDE_BUY, 32'sd0, 32'd0));

        for (int i = 0; i < 245; i++) queue_cmd(rand_cmd());

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
